// ===== design/ptfp_pkg.sv =====
package ptfp_pkg;
  localparam int POSE_BYTES_DEF = 24;
  localparam int QDEPTH = 2;
  localparam logic [7:0] HDR_POSE_A = 8'hAA;
  localparam logic [7:0] HDR_POSE_B = 8'hFF;
  localparam logic [7:0] TAIL_POSE = 8'hEA;
  localparam logic [7:0] HDR_TGT_A = 8'hAB;
  localparam logic [7:0] HDR_TGT_B = 8'hFB;
  localparam logic [7:0] TAIL_TGT = 8'hEB;
  localparam logic [1:0] REG_OUTLIER = 2'd0;
  localparam logic [1:0] REG_JUMP = 2'd1;
  localparam logic [1:0] REG_ERRLIM = 2'd2;
  localparam logic [1:0] REG_NOTGT = 2'd3;
  localparam logic KIND_POSE = 1'b0;
  localparam logic KIND_TARGET = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } job_t;

  typedef struct packed {
    logic               frame_kind;
    logic signed [31:0] pos_x_cm;
    logic signed [31:0] pos_y_cm;
    logic signed [31:0] pos_z_cm;
    logic signed [31:0] vel_x_cms;
    logic signed [31:0] vel_y_cms;
    logic signed [31:0] vel_z_cms;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic               target_found;
    logic [7:0]         lost_count;
  } result_t;

  typedef struct packed {
    logic [30:0]        outlier_limit;
    logic [15:0]        jump_limit;
    logic [7:0]         error_limit;
    logic signed [15:0] no_target_code;
  } cfg_t;

  function automatic logic signed [31:0] single_to_q16(input logic [31:0] b);
    logic [7:0] e;
    logic [23:0] m;
    logic [31:0] mag;
    logic [4:0] rs;
    e = b[30:23];
    m = {1'b1, b[22:0]};
    mag = '0;
    rs = '0;
    if (e == 8'd0 || (e == 8'hFF && b[22:0] != 23'd0)) begin
      single_to_q16 = '0;
    end else if (e >= 8'd142) begin
      single_to_q16 = b[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      if (e >= 8'd134) begin
        mag = {8'd0, m} << (e - 8'd134);
      end else if (e > 8'd110) begin
        rs = 5'(8'd134 - e);
        mag = {8'd0, m >> rs};
      end
      single_to_q16 = b[31] ? -$signed(mag) : $signed(mag);
    end
  endfunction
endpackage

// ===== design/ptfp_if.sv =====
interface ptfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  modport source(output valid, byte_in, input ready);
  modport sink(input valid, byte_in, output ready);
endinterface

interface ptfp_result_if;
  import ptfp_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

interface ptfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/ptfp_front.sv =====
module ptfp_front
  import ptfp_pkg::*;
#(
  parameter int POSE_BYTES = POSE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_byte,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);
  localparam int CW = $clog2(POSE_BYTES + 1);
  localparam int AW = $clog2(POSE_BYTES);
  localparam int NV = POSE_BYTES / 4;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_PB = 7'b0000010, S_PPAY = 7'b0000100,
    S_PTAIL = 7'b0001000, S_TB = 7'b0010000, S_TPAY = 7'b0100000,
    S_TTAIL = 7'b1000000
  } phase_t;

  phase_t phase;
  logic [CW-1:0] byte_count;
  logic [7:0] buffer [POSE_BYTES];
  logic [2:0] emit_idx;
  logic emitting;
  logic emit_kind;
  logic [2:0] emit_last;
  logic acc;
  logic [31:0] word;
  logic [AW-1:0] base;

  assign in_ready = !emitting;
  assign acc = in_valid && in_ready;
  assign base = AW'({emit_idx, 2'b00});
  assign word = {buffer[base + AW'(3)], buffer[base + AW'(2)], buffer[base + AW'(1)],
                 buffer[base]};
  assign job_valid = emitting;
  assign job = '{kind: emit_kind, word: word, idx: emit_idx, last: emit_idx == emit_last};

  always_ff @(posedge clk) begin
    if (acc && (phase == S_PPAY || phase == S_TPAY)) begin
      buffer[byte_count[AW-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= S_IDLE;
      byte_count <= '0;
      emitting <= 1'b0;
      emit_idx <= '0;
      emit_kind <= KIND_POSE;
      emit_last <= '0;
    end else begin
      if (emitting && job_ready) begin
        if (emit_idx == emit_last) emitting <= 1'b0;
        else emit_idx <= emit_idx + 3'd1;
      end
      if (acc) begin
        unique case (phase)
          S_PB: if (in_byte == HDR_POSE_B) phase <= S_PPAY;
          S_PPAY: begin
            byte_count <= byte_count + 1'b1;
            if (byte_count == CW'(POSE_BYTES - 1)) phase <= S_PTAIL;
          end
          S_PTAIL: begin
            phase <= S_IDLE;
            if (in_byte == TAIL_POSE) begin
              emitting <= 1'b1;
              emit_idx <= '0;
              emit_kind <= KIND_POSE;
              emit_last <= 3'(NV - 1);
            end
          end
          S_TB: if (in_byte == HDR_TGT_B) phase <= S_TPAY;
          S_TPAY: begin
            byte_count <= byte_count + 1'b1;
            if (byte_count == CW'(3)) phase <= S_TTAIL;
          end
          S_TTAIL: begin
            phase <= S_IDLE;
            if (in_byte == TAIL_TGT) begin
              emitting <= 1'b1;
              emit_idx <= '0;
              emit_kind <= KIND_TARGET;
              emit_last <= '0;
            end
          end
          default: begin
            byte_count <= '0;
            if (in_byte == HDR_POSE_A) phase <= S_PB;
            else if (in_byte == HDR_TGT_A) phase <= S_TB;
            else phase <= S_IDLE;
          end
        endcase
      end
    end
  end
endmodule

// ===== design/ptfp_queue.sv =====
module ptfp_queue
  import ptfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);
  job_t slot [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp, rp;
  logic [$clog2(QDEPTH):0] cnt;
  logic push, pop;

  assign in_ready = cnt != ($clog2(QDEPTH)+1)'(QDEPTH);
  assign out_valid = cnt != '0;
  assign out_job = slot[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end
endmodule

// ===== design/ptfp_back.sv =====
module ptfp_back
  import ptfp_pkg::*;
#(
  parameter int POSE_BYTES = POSE_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    job_valid,
  output logic    job_ready,
  input  job_t    job,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);
  localparam int NV = POSE_BYTES / 4;

  // Stage 1 converts and rejects outliers; stage 2 scales and filters.
  logic signed [31:0] prev_raw [NV];
  logic signed [31:0] filt [NV];
  logic signed [15:0] cur_c [2];
  logic signed [15:0] prev_c [2];
  logic [7:0] err_cnt;
  logic found, seen;

  logic s1_valid, s1_last;
  logic [2:0] s1_slot;
  logic signed [32:0] s1_samp;
  logic s2_valid;
  logic s2_kind;
  logic res_pending;
  logic stall;

  logic signed [31:0] conv, used;
  logic signed [32:0] diff, adiff;
  logic signed [40:0] scaled;
  logic signed [32:0] sample;
  logic signed [33:0] delta;
  logic [2:0] slot;
  logic signed [15:0] tx, ty;
  logic signed [16:0] dx, dy;
  logic [16:0] adx, ady;

  assign stall = res_valid && !res_ready;
  assign job_ready = !stall && !s1_valid && !s2_valid;

  always_comb begin
    conv = single_to_q16(job.word);
    diff = 33'(conv) - 33'(prev_raw[job.idx]);
    adiff = diff[32] ? -diff : diff;
    used = (adiff > $signed({2'b00, cfg.outlier_limit})) ? prev_raw[job.idx] : conv;
    unique case (job.idx)
      3'd0: slot = 3'd1;
      3'd1: slot = 3'd0;
      3'd3: slot = 3'd4;
      3'd4: slot = 3'd3;
      default: slot = job.idx;
    endcase
    tx = $signed(job.word[15:0]);
    ty = $signed(job.word[31:16]);
    dx = 17'(tx) - 17'(cur_c[0]);
    dy = 17'(ty) - 17'(cur_c[1]);
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
    scaled = s1_samp * 41'sd100;
    sample = 33'(scaled >>> 8);
    delta = 34'(sample) - 34'(filt[s1_slot]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NV; i++) begin
        prev_raw[i] <= '0;
        filt[i] <= '0;
      end
      cur_c[0] <= '0; cur_c[1] <= '0;
      prev_c[0] <= '0; prev_c[1] <= '0;
      err_cnt <= '0;
      found <= 1'b0;
      seen <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s2_kind <= KIND_POSE;
      res_pending <= 1'b0;
    end else begin
      s1_valid <= job_valid && job_ready && job.kind == KIND_POSE;
      s2_valid <= (s1_valid && s1_last) ||
                  (job_valid && job_ready && job.kind == KIND_TARGET);
      res_pending <= s2_valid || (res_pending && !res_ready);
      if (s1_valid) begin
        filt[s1_slot] <= 32'(34'(filt[s1_slot]) + (delta >>> 1));
        if (s1_last) s2_kind <= KIND_POSE;
      end
      if (job_valid && job_ready) begin
        if (job.kind == KIND_POSE) begin
          prev_raw[job.idx] <= used;
          s1_slot <= slot;
          s1_last <= job.last;
          s1_samp <= (job.idx == 3'd1 || job.idx == 3'd3) ? -33'(used) : 33'(used);
        end else begin
          if (tx == cfg.no_target_code) begin
            if (err_cnt != 8'hFF) begin
              err_cnt <= err_cnt + 8'd1;
              if (err_cnt + 8'd1 > cfg.error_limit) found <= 1'b0;
            end else if (err_cnt > cfg.error_limit) found <= 1'b0;
          end else begin
            found <= 1'b1;
            if (seen && (adx > {1'b0, cfg.jump_limit} || ady > {1'b0, cfg.jump_limit})) begin
              cur_c[0] <= prev_c[0];
              cur_c[1] <= prev_c[1];
            end else begin
              prev_c[0] <= cur_c[0];
              prev_c[1] <= cur_c[1];
              cur_c[0] <= tx;
              cur_c[1] <= ty;
            end
          end
          seen <= 1'b1;
          s2_kind <= KIND_TARGET;
        end
      end
    end
  end

  assign res_valid = res_pending;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      res.frame_kind <= s2_kind;
      res.pos_x_cm <= filt[0];
      res.pos_y_cm <= filt[1];
      res.pos_z_cm <= filt[2];
      res.vel_x_cms <= filt[3];
      res.vel_y_cms <= filt[4];
      res.vel_z_cms <= filt[5];
      res.centre_x <= cur_c[0];
      res.centre_y <= cur_c[1];
      res.target_found <= found;
      res.lost_count <= err_cnt;
    end
  end
endmodule

// ===== design/pose_and_target_frame_parser.sv =====
// Byte-serial parser for pose and target frames. One byte is taken per cycle while the
// front end is not unloading a finished frame. The back end takes no new pose value until
// the previous one has left stage 1, so with an idle back end a completed pose frame holds
// the input after its tail while its six words pass through the queue; a target frame holds
// it while its one word does. A pose result passes stage 1, stage 2 and the output register
// after its last value, a target result skips stage 1, and either is held there until
// transferred. A result still waiting holds the back end, and the input once the queue fills.
module pose_and_target_frame_parser
  import ptfp_pkg::*;
#(
  parameter int POSE_BYTES = POSE_BYTES_DEF
) (
  input logic clk,
  input logic rst,
  ptfp_byte_if.sink in,
  ptfp_result_if.source out,
  ptfp_cfg_if.sink cfg
);
  cfg_t regs;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{outlier_limit: 31'd13107, jump_limit: 16'd140, error_limit: 8'd5,
                no_target_code: 16'sd6000};
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_OUTLIER: regs.outlier_limit <= cfg.data[30:0];
        REG_JUMP: regs.jump_limit <= cfg.data[15:0];
        REG_ERRLIM: regs.error_limit <= cfg.data[7:0];
        REG_NOTGT: regs.no_target_code <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  ptfp_front #(.POSE_BYTES(POSE_BYTES)) u_front (
    .clk, .rst, .in_valid(in.valid), .in_ready(in.ready), .in_byte(in.byte_in),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );
  ptfp_queue u_queue (
    .clk, .rst, .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
    .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
  );
  ptfp_back #(.POSE_BYTES(POSE_BYTES)) u_back (
    .clk, .rst, .cfg(regs), .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .res_valid(out.valid), .res_ready(out.ready), .res(out.data)
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.data))
    else $error("result changed while stalled");
  a_queue: assert property (@(posedge clk) disable iff (rst)
    bj_valid && !bj_ready |=> bj_valid)
    else $error("queue lost a job");
endmodule
